### sv/segx_pkg.sv
`default_nettype none
package segx_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DELTA_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int SQ_BITS    = PROD_BITS;
  localparam int RAD_BITS   = SQ_BITS + 16;
  localparam int ROOT_BITS  = RAD_BITS / 2;
  localparam int SREM_BITS  = ROOT_BITS + 2;
  localparam int DIST_BITS  = 25;
  localparam int CROSS_BITS = 24;
  localparam int IN_BITS    = 8 * COORD_BITS;
  localparam int OUT_BITS   = 80;

  typedef struct packed {
    logic                          hit;
    logic signed [DELTA_BITS-1:0]  dx;
    logic signed [DELTA_BITS-1:0]  dy;
    logic signed [COORD_BITS-1:0]  px;
    logic signed [COORD_BITS-1:0]  py;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [SUM_BITS-1:0]  den;
    logic [SUM_BITS-1:0]  rnum;
    logic [SQ_BITS-1:0]   sq;
  } front_t;

  typedef struct packed {
    side_t                 side;
    logic [FRAC_BITS-1:0]  rq;
    logic [ROOT_BITS-1:0]  len8;
  } core_t;

  typedef struct packed {
    logic                          hit;
    logic [DIST_BITS-1:0]          distance;
    logic signed [CROSS_BITS-1:0]  cx;
    logic signed [CROSS_BITS-1:0]  cy;
  } res_t;

endpackage
`default_nettype wire

### sv/segx_front.sv
`default_nettype none
module segx_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        ce,
  input  wire logic                        in_valid,
  input  wire logic [segx_pkg::IN_BITS-1:0] in_data,
  output logic                             out_valid,
  output segx_pkg::front_t                 out_item
);

  localparam int CB = segx_pkg::COORD_BITS;
  localparam int DB = segx_pkg::DELTA_BITS;
  localparam int PB = segx_pkg::PROD_BITS;
  localparam int SB = segx_pkg::SUM_BITS;
  localparam int QB = segx_pkg::SQ_BITS;

  logic signed [DB-1:0] c [8];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      c[i] = $signed({in_data[CB*i+CB-1], in_data[CB*i +: CB]});
    end
  end

  // stage 1: deltas
  logic                 v1;
  logic signed [DB-1:0] dx1, dy1, wx1, wy1, ox1, oy1;
  logic signed [CB-1:0] px1, py1;
  // stage 2: products
  logic                 v2;
  logic signed [PB-1:0] m_dwy, m_dywx, m_oywx, m_oxwy, m_oydx, m_oxdy, m_dxdx, m_dydy;
  logic signed [DB-1:0] dx2, dy2;
  logic signed [CB-1:0] px2, py2;
  // stage 3: sums
  logic                 v3;
  logic signed [SB-1:0] den3, rn3, sn3;
  logic [QB-1:0]        sq3;
  logic signed [DB-1:0] dx3, dy3;
  logic signed [CB-1:0] px3, py3;
  // stage 4: sign fold
  logic                 v4;
  logic signed [SB-1:0] dm4, rn4, sn4;
  logic [QB-1:0]        sq4;
  logic signed [DB-1:0] dx4, dy4;
  logic signed [CB-1:0] px4, py4;
  // stage 5: open interval test
  logic                 v5;
  logic                 hit5;
  logic [SB-1:0]        dm5, rn5;
  logic [QB-1:0]        sq5;
  logic signed [DB-1:0] dx5, dy5;
  logic signed [CB-1:0] px5, py5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dx1 <= c[2] - c[0];
      dy1 <= c[3] - c[1];
      wx1 <= c[6] - c[4];
      wy1 <= c[7] - c[5];
      ox1 <= c[0] - c[4];
      oy1 <= c[1] - c[5];
      px1 <= in_data[0 +: CB];
      py1 <= in_data[CB +: CB];

      m_dwy  <= dx1 * wy1;
      m_dywx <= dy1 * wx1;
      m_oywx <= oy1 * wx1;
      m_oxwy <= ox1 * wy1;
      m_oydx <= oy1 * dx1;
      m_oxdy <= ox1 * dy1;
      m_dxdx <= dx1 * dx1;
      m_dydy <= dy1 * dy1;
      dx2 <= dx1;
      dy2 <= dy1;
      px2 <= px1;
      py2 <= py1;

      den3 <= {m_dwy[PB-1], m_dwy} - {m_dywx[PB-1], m_dywx};
      rn3  <= {m_oywx[PB-1], m_oywx} - {m_oxwy[PB-1], m_oxwy};
      sn3  <= {m_oydx[PB-1], m_oydx} - {m_oxdy[PB-1], m_oxdy};
      sq3  <= QB'(m_dxdx) + QB'(m_dydy);
      dx3 <= dx2;
      dy3 <= dy2;
      px3 <= px2;
      py3 <= py2;

      dm4 <= den3[SB-1] ? -den3 : den3;
      rn4 <= den3[SB-1] ? -rn3 : rn3;
      sn4 <= den3[SB-1] ? -sn3 : sn3;
      sq4 <= sq3;
      dx4 <= dx3;
      dy4 <= dy3;
      px4 <= px3;
      py4 <= py3;

      hit5 <= (dm4 != '0) && (rn4 > 0) && (rn4 < dm4) && (sn4 > 0) && (sn4 < dm4);
      dm5  <= dm4;
      rn5  <= rn4;
      sq5  <= sq4;
      dx5  <= dx4;
      dy5  <= dy4;
      px5  <= px4;
      py5  <= py4;
    end
  end

  assign out_valid          = v5;
  assign out_item.side.hit  = hit5;
  assign out_item.side.dx   = dx5;
  assign out_item.side.dy   = dy5;
  assign out_item.side.px   = px5;
  assign out_item.side.py   = py5;
  assign out_item.den       = dm5;
  assign out_item.rnum      = rn5;
  assign out_item.sq        = sq5;

endmodule
`default_nettype wire

### sv/segx_core.sv
`default_nettype none
module segx_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ce,
  input  wire logic             in_valid,
  input  segx_pkg::front_t      in_item,
  output logic                  out_valid,
  output segx_pkg::core_t       out_item
);

  localparam int SB = segx_pkg::SUM_BITS;
  localparam int FB = segx_pkg::FRAC_BITS;
  localparam int RB = segx_pkg::RAD_BITS;
  localparam int TB = segx_pkg::ROOT_BITS;
  localparam int MB = segx_pkg::SREM_BITS;
  localparam int NS = TB;

  typedef struct packed {
    segx_pkg::side_t side;
    logic [SB-1:0]   den;
    logic [SB-1:0]   rem;
    logic [FB-1:0]   q;
    logic [RB-1:0]   sx;
    logic [MB-1:0]   srem;
    logic [TB-1:0]   root;
  } step_t;

  step_t st  [NS+1];
  logic  vld [NS+1];

  always_comb begin
    st[0].side = in_item.side;
    st[0].den  = in_item.den;
    st[0].rem  = in_item.rnum;
    st[0].q    = '0;
    st[0].sx   = {in_item.sq, 16'b0};
    st[0].srem = '0;
    st[0].root = '0;
    vld[0]     = in_valid;
  end

  // one quotient bit (first FRAC_BITS stages) and one root bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_stage
    step_t        nxt;
    logic [SB:0]  t;
    logic [MB+1:0] cur;
    logic [MB-1:0] trial;

    always_comb begin
      nxt   = st[i];
      t     = {st[i].rem, 1'b0};
      cur   = {st[i].srem, st[i].sx[RB-1 -: 2]};
      trial = {st[i].root, 2'b01};
      if (i < FB) begin
        if (t >= {1'b0, st[i].den}) begin
          nxt.rem = SB'(t - {1'b0, st[i].den});
          nxt.q   = {st[i].q[FB-2:0], 1'b1};
        end else begin
          nxt.rem = SB'(t);
          nxt.q   = {st[i].q[FB-2:0], 1'b0};
        end
      end
      if (cur >= {2'b00, trial}) begin
        nxt.srem = MB'(cur - {2'b00, trial});
        nxt.root = {st[i].root[TB-2:0], 1'b1};
      end else begin
        nxt.srem = MB'(cur);
        nxt.root = {st[i].root[TB-2:0], 1'b0};
      end
      nxt.sx = {st[i].sx[RB-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (ce) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_valid     = vld[NS];
  assign out_item.side = st[NS].side;
  assign out_item.rq   = st[NS].q;
  assign out_item.len8 = st[NS].root;

endmodule
`default_nettype wire

### sv/segx_back.sv
`default_nettype none
module segx_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ce,
  input  wire logic          in_valid,
  input  segx_pkg::core_t    in_item,
  output logic               out_valid,
  output segx_pkg::res_t     out_item
);

  localparam int CB = segx_pkg::COORD_BITS;
  localparam int FB = segx_pkg::FRAC_BITS;
  localparam int TB = segx_pkg::ROOT_BITS;
  localparam int DB = segx_pkg::DIST_BITS;
  localparam int XB = segx_pkg::CROSS_BITS;
  localparam int LB = TB + FB;
  localparam int OB = FB + CB;

  logic          v1;
  logic          hit1, negx1, negy1;
  logic [LB-1:0] pd1;
  logic [OB-1:0] offx1, offy1;
  logic signed [CB-1:0] px1, py1;
  logic [CB-1:0] adx, ady;
  logic signed [XB-1:0] basex, basey;
  logic [XB-1:0] ox, oy;

  logic           v2;
  segx_pkg::res_t r2;

  always_comb begin
    adx   = in_item.side.dx[CB] ? CB'(-in_item.side.dx) : CB'(in_item.side.dx);
    ady   = in_item.side.dy[CB] ? CB'(-in_item.side.dy) : CB'(in_item.side.dy);
    basex = {px1, 8'b0};
    basey = {py1, 8'b0};
    ox    = XB'(offx1 >> (FB - 8));
    oy    = XB'(offy1 >> (FB - 8));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hit1  <= in_item.side.hit;
      negx1 <= in_item.side.dx[CB];
      negy1 <= in_item.side.dy[CB];
      pd1   <= LB'(in_item.len8) * LB'(in_item.rq);
      offx1 <= OB'(in_item.rq) * OB'(adx);
      offy1 <= OB'(in_item.rq) * OB'(ady);
      px1   <= in_item.side.px;
      py1   <= in_item.side.py;

      r2.hit      <= hit1;
      r2.distance <= hit1 ? DB'(pd1 >> FB) : '0;
      r2.cx       <= hit1 ? (negx1 ? basex - $signed(ox) : basex + $signed(ox)) : '0;
      r2.cy       <= hit1 ? (negy1 ? basey - $signed(oy) : basey + $signed(oy)) : '0;
    end
  end

  assign out_valid = v2;
  assign out_item  = r2;

endmodule
`default_nettype wire

### sv/segx_outq.sv
`default_nettype none
module segx_outq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  segx_pkg::res_t                     push_item,
  output logic                               ce,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [segx_pkg::OUT_BITS-1:0]      m_tdata,
  output logic [0:0]                         m_tuser
);

  localparam int PB = segx_pkg::DIST_BITS + 2 * segx_pkg::CROSS_BITS;

  logic [1:0]     cnt;
  segx_pkg::res_t e0, e1;
  logic           pop;

  assign ce       = (cnt != 2'd2);
  assign m_tvalid = (cnt != 2'd0);
  assign pop      = m_tvalid & m_tready;
  assign m_tdata  = {{(segx_pkg::OUT_BITS - PB){1'b0}}, e0.cy, e0.cx, e0.distance};
  assign m_tuser  = e0.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        e0 <= push_item;
      end else begin
        e0 <= e1;
        e1 <= push_item;
      end
    end else if (pop) begin
      e0 <= e1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= push_item;
      end else begin
        e1 <= push_item;
      end
    end
  end

endmodule
`default_nettype wire

### sv/segment_intersection_2d.sv
// channel | dir | tdata (low bit up)                                   | tuser
// s_      | in  | probe_start_x/y, probe_end_x/y, wall_first_x/y,       | -
//         |     | wall_second_x/y, 16 bits each                         |
// m_      | out | hit_distance 25, cross_x 24, cross_y 24, 7 zero bits  | hit
//
// One segment pair per cycle while s_tready is high.
// The pipeline depth is set mostly by the 25-step square root pipeline (the 16-bit
// quotient of r shares its first 16 stages).
// rst clears all valid bits and the two-entry output queue.
// s_tready drops only when the output queue holds two results; the whole
// pipeline then holds.
`default_nettype none
module segment_intersection_2d (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [segx_pkg::IN_BITS-1:0]  s_tdata,  // psx, psy, pex, pey, wfx, wfy, wsx, wsy
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [segx_pkg::OUT_BITS-1:0]      m_tdata,  // hit_distance, cross_x, cross_y
  output logic [0:0]                         m_tuser   // hit
);

  logic             ce;
  logic             f_valid, c_valid, b_valid;
  segx_pkg::front_t f_item;
  segx_pkg::core_t  c_item;
  segx_pkg::res_t   b_item;

  assign s_tready = ce;

  segx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  segx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .out_valid (c_valid),
    .out_item  (c_item)
  );

  segx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (c_valid),
    .in_item   (c_item),
    .out_valid (b_valid),
    .out_item  (b_item)
  );

  segx_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (b_valid & ce),
    .push_item (b_item),
    .ce        (ce),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

### sv/segx_check.sv
`default_nettype none
module segx_check (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [segx_pkg::OUT_BITS-1:0] m_tdata,
  input wire logic [0:0]                   m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss with nonzero payload");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not empty after reset");

  a_pipe_min: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !rst && s_tvalid && s_tready |=> !m_tvalid)
    else $error("result too early after reset");

endmodule

bind segment_intersection_2d segx_check u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
